/* hw/rtl/chm_pkg.sv */
// Package for the chained hash multimap: payload word types, status codes and
// shared sizing constants. Used by every module in hw/rtl.
package chm_pkg;

    localparam int MAX_BUCKETS_DEF = 256;
    localparam int SLOTS_DEF       = 1024;
    localparam int KEY_BITS_DEF    = 64;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] hash_value;
        logic [63:0] key;
        logic [9:0]  match_index;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] slot;
    } out_word_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;      // capture input word, start modulo
        logic mod_step;  // one restoring step of hash mod bucket count
        logic head_rd;   // read bucket head
        logic cur_ld;    // load cursor from bucket head
        logic ent_rd;    // read entry at cursor
        logic adv;       // advance cursor to next link
        logic hit_inc;   // count a match
        logic wr_new;    // write new entry at slots_used
        logic wr_head;   // new entry becomes bucket head
        logic wr_tail;   // link new entry after cursor
        logic res_ok;    // result: ok with slot
        logic res_found; // result: ok with cursor slot
        logic res_nf;    // result: not found
        logic res_full;  // result: table full
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic is_lookup;
        logic full;
        logic mod_done;
        logic head_valid;
        logic next_valid;
        logic match;
        logic hit_last;
        logic steps_done;
    } sts_t;

endpackage

/* hw/rtl/chm_datapath.sv */
// Datapath of the chained hash multimap: bucket heads, entry memories,
// iterative modulo unit, walk cursor and result register. Uses chm_pkg.
module chm_datapath #(
    parameter int MAX_BUCKETS = chm_pkg::MAX_BUCKETS_DEF,
    parameter int SLOTS       = chm_pkg::SLOTS_DEF,
    parameter int KEY_BITS    = chm_pkg::KEY_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [8:0]        cfg_data,
    input  chm_pkg::in_word_t in_word,
    input  chm_pkg::cmd_t     cmd,
    output chm_pkg::sts_t     sts,
    output chm_pkg::out_word_t res
);
    import chm_pkg::*;

    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int NW = $clog2(MAX_BUCKETS + 1);

    logic [8:0]  bcount_reg;
    logic [NW-1:0] nb;
    logic [NW-1:0] bcnt_ext;

    logic        op_reg;
    logic [31:0] hash_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [9:0]  want_reg;
    logic [31:0] quot_reg;
    logic [NW:0] rem_reg;
    logic [5:0]  mstep_reg;
    logic [NW:0] rem_sh;

    logic [MAX_BUCKETS-1:0] hv_reg;
    logic [SW-1:0] head_mem [MAX_BUCKETS];
    logic [31:0]   ehash_mem [SLOTS];
    logic [KEY_BITS-1:0] ekey_mem [SLOTS];
    logic [SW:0]   enext_mem [SLOTS];

    logic [SW-1:0] cur_reg;
    logic [SW-1:0] head_q;
    logic [31:0]   ehash_q;
    logic [KEY_BITS-1:0] ekey_q;
    logic [SW:0]   enext_q;
    logic          head_v_reg;
    logic [CW-1:0] used_reg;
    logic [CW-1:0] steps_reg;
    logic [9:0]    hits_reg;
    logic [BW-1:0] bkt;
    out_word_t     res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bcount_reg <= 9'd256;
        else if (cfg_we)
            bcount_reg <= cfg_data;
    end

    // Clamp bucket count to 1..MAX_BUCKETS.
    assign bcnt_ext = (NW >= 9) ? NW'(bcount_reg) : NW'(bcount_reg);
    always_comb
    begin
        if (bcount_reg == 9'd0)
            nb = NW'(1);
        else if ({23'd0, bcount_reg} > 32'(MAX_BUCKETS))
            nb = NW'(MAX_BUCKETS);
        else
            nb = bcnt_ext;
    end

    assign rem_sh = {rem_reg[NW-1:0], quot_reg[31]};
    assign bkt = BW'(rem_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_word.op;
            hash_reg <= in_word.hash_value;
            key_reg  <= in_word.key[KEY_BITS-1:0];
            want_reg <= in_word.match_index;
            quot_reg <= in_word.hash_value;
            rem_reg  <= '0;
            mstep_reg <= 6'd0;
        end
        else if (cmd.mod_step)
        begin
            quot_reg <= {quot_reg[30:0], 1'b0};
            if (rem_sh >= {1'b0, nb})
                rem_reg <= rem_sh - {1'b0, nb};
            else
                rem_reg <= rem_sh;
            mstep_reg <= mstep_reg + 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg   <= '0;
            used_reg <= '0;
        end
        else
        begin
            if (cmd.wr_head)
                hv_reg[bkt] <= 1'b1;
            if (cmd.wr_new)
                used_reg <= used_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_head)
            head_mem[bkt] <= used_reg[SW-1:0];
        if (cmd.head_rd)
        begin
            head_q     <= head_mem[bkt];
            head_v_reg <= hv_reg[bkt];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_new)
        begin
            ehash_mem[used_reg[SW-1:0]] <= hash_reg;
            ekey_mem[used_reg[SW-1:0]]  <= key_reg;
        end
        if (cmd.ent_rd)
        begin
            ehash_q <= ehash_mem[cur_reg];
            ekey_q  <= ekey_mem[cur_reg];
        end
    end

    // Link memory: one write port, one read port.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_new)
            enext_mem[used_reg[SW-1:0]] <= '0;
        else if (cmd.wr_tail)
            enext_mem[cur_reg] <= {1'b1, used_reg[SW-1:0]};
        if (cmd.ent_rd)
            enext_q <= enext_mem[cur_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.head_rd)
        begin
            steps_reg <= '0;
            hits_reg  <= '0;
        end
        else
        begin
            if (cmd.hit_inc)
                hits_reg <= hits_reg + 10'd1;
            if (cmd.adv)
                steps_reg <= steps_reg + CW'(1);
        end
        if (cmd.adv)
            cur_reg <= enext_q[SW-1:0];
        else if (cmd.cur_ld)
            cur_reg <= head_q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_reg <= '0;
        else if (cmd.res_ok)
            res_reg <= '{status: ST_OK, slot: 10'(used_reg - CW'(1))};
        else if (cmd.res_found)
            res_reg <= '{status: ST_OK, slot: 10'(cur_reg)};
        else if (cmd.res_nf)
            res_reg <= '{status: ST_NOT_FOUND, slot: 10'd0};
        else if (cmd.res_full)
            res_reg <= '{status: ST_FULL, slot: 10'd0};
    end

    assign res = res_reg;

    always_comb
    begin
        sts.is_lookup  = (op_reg == OP_LOOKUP);
        sts.full       = (used_reg == CW'(SLOTS));
        sts.mod_done   = (mstep_reg == 6'd32);
        sts.head_valid = head_v_reg;
        sts.next_valid = enext_q[SW];
        sts.match      = (ehash_q == hash_reg) && (ekey_q == key_reg);
        sts.hit_last   = (hits_reg == want_reg);
        sts.steps_done = (steps_reg >= CW'(SLOTS - 1));
    end

endmodule

/* hw/rtl/chm_ctrl.sv */
// Controller state machine of the chained hash multimap. Sequences the
// modulo, head read and chain walk. Uses chm_pkg.
module chm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  chm_pkg::sts_t  sts,
    output chm_pkg::cmd_t  cmd
);
    import chm_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MOD   = 4'd1;
    localparam logic [3:0] S_HEAD  = 4'd2;
    localparam logic [3:0] S_DEC   = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_OUT   = 4'd6;
    localparam logic [3:0] S_NEW   = 4'd7;

    logic [3:0] state_reg, state_next;
    logic       ov_reg, ov_next;

    assign in_ready  = (state_reg == S_IDLE) && (!ov_reg || out_ready);
    assign out_valid = ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (sts.mod_done)
                begin
                    cmd.head_rd = 1'b1;
                    state_next  = S_HEAD;
                end
                else
                    cmd.mod_step = 1'b1;
            end
            S_HEAD:
            begin
                if (!sts.is_lookup && sts.full)
                begin
                    cmd.res_full = 1'b1;
                    state_next   = S_OUT;
                end
                else if (!sts.head_valid)
                begin
                    if (sts.is_lookup)
                        cmd.res_nf = 1'b1;
                    else
                    begin
                        cmd.wr_new  = 1'b1;
                        cmd.wr_head = 1'b1;
                    end
                    state_next = S_DEC;
                end
                else
                begin
                    cmd.cur_ld = 1'b1;
                    state_next = S_RD;
                end
            end
            S_DEC:
            begin
                if (!sts.is_lookup)
                    cmd.res_ok = 1'b1;
                state_next = S_OUT;
            end
            S_RD:
            begin
                cmd.ent_rd = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (sts.is_lookup && sts.match && sts.hit_last)
                begin
                    cmd.res_found = 1'b1;
                    state_next    = S_OUT;
                end
                else if (!sts.next_valid || sts.steps_done)
                begin
                    if (sts.is_lookup)
                        cmd.res_nf = 1'b1;
                    else
                        cmd.wr_tail = 1'b1;
                    state_next = sts.is_lookup ? S_OUT : S_NEW;
                end
                else
                begin
                    cmd.hit_inc = sts.is_lookup && sts.match;
                    cmd.adv     = 1'b1;
                    state_next  = S_RD;
                end
            end
            // The link memory has one write port, so the new entry is
            // written in the cycle after the tail link.
            S_NEW:
            begin
                cmd.wr_new = 1'b1;
                state_next = S_DEC;
            end
            S_OUT:
            begin
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

/* hw/rtl/chained_hash_multimap_core.sv */
// Top level of the chained hash multimap: controller plus datapath.
// Depends on chm_pkg, chm_ctrl and chm_datapath.
//
// One word at a time. Every word first runs a bit-serial hash mod
// bucket_count (32 steps, then a read of the bucket head), then walks
// its bucket chain link by link (cursor load or advance, then a
// registered entry read and compare). A lookup stops at the wanted match or
// at the end of the chain. An insert becomes the bucket head or is linked
// behind the last entry, and is rejected without a walk if the table is full.
// The result register holds the answer until taken; the next word can be
// accepted in the cycle the previous result is taken. No clearing pass.
module chained_hash_multimap_core #(
    parameter int MAX_BUCKETS = chm_pkg::MAX_BUCKETS_DEF,
    parameter int SLOTS       = chm_pkg::SLOTS_DEF,
    parameter int KEY_BITS    = chm_pkg::KEY_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [8:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  chm_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output chm_pkg::out_word_t out_data
);
    import chm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    chm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    chm_datapath #(
        .MAX_BUCKETS(MAX_BUCKETS),
        .SLOTS      (SLOTS),
        .KEY_BITS   (KEY_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data),
        .in_word (in_data),
        .cmd     (cmd),
        .sts     (sts),
        .res     (out_data)
    );

`ifndef ASSERT_OFF
    a_no_double_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_tail && (cmd.wr_new || cmd.wr_head)))
        else $error("tail link written together with the new entry");
    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.status == ST_OK) || (out_data.status == ST_NOT_FOUND)
                       || (out_data.status == ST_FULL)))
        else $error("illegal status");
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("accepted a word while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result word changed before it was taken");
`endif

endmodule
